FILE: design/mine_constraint_checker_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef MINE_CONSTRAINT_CHECKER_UNIT_MACROS_SVH
`define MINE_CONSTRAINT_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcc assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcc assertion failed");

`endif

FILE: design/mcc_pkg.sv
package mcc_pkg;

  // Table geometry.
  localparam int MAX_ROWS  = 64;
  localparam int MASK_BITS = 32;
  localparam int ROW_BYTES = 9;
  localparam int NB_COUNT  = ROW_BYTES - 1;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int SLOT_W    = 4;
  localparam int TOT_W     = $clog2(MASK_BITS + 1);

  // Neighbour flag codes.
  localparam logic [1:0] FLAG_MINE = 2'd1;
  localparam logic [1:0] FLAG_SAFE = 2'd2;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROW_COUNT       = 2'd0;
  localparam logic [1:0] REG_REMAINING_MINES = 2'd1;
  localparam logic [1:0] REG_ALL_IN_BORDER   = 2'd2;

  typedef logic [ROW_BYTES-1:0][7:0] row_t;

  // Access request to the constraint table.
  typedef struct packed {
    logic              we;
    logic [ROW_W-1:0]  wrow;
    logic [SLOT_W-1:0] wslot;
    logic [7:0]        wdata;
    logic              re;
    logic [ROW_W-1:0]  raddr;
  } ram_req_t;

  // Population count by the usual bit-parallel reduction.
  function automatic logic [TOT_W-1:0] popcount(input logic [MASK_BITS-1:0] v);
    logic [31:0] x;
    logic [7:0]  s;
    x = 32'(v);
    x = x - ((x >> 1) & 32'h5555_5555);
    x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
    x = (x + (x >> 4)) & 32'h0F0F_0F0F;
    s = x[7:0] + x[15:8] + x[23:16] + x[31:24];
    return TOT_W'(s);
  endfunction

endpackage

FILE: design/mcc_table_ram.sv
module mcc_table_ram (
  input  logic              clk,
  input  mcc_pkg::ram_req_t req,
  output mcc_pkg::row_t     rdata
);

  mcc_pkg::row_t mem [mcc_pkg::MAX_ROWS];
  mcc_pkg::row_t rdata_r;

  // Byte-wide write into one row, whole-row read registered.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wrow][req.wslot] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mcc_row_eval.sv
module mcc_row_eval (
  input  mcc_pkg::row_t                  row_data,
  input  logic [mcc_pkg::MASK_BITS-1:0]  cand,
  output logic                           row_ok
);

  logic [3:0] hint;
  logic [3:0] n_raw;
  logic [3:0] n_sat;
  logic [3:0] mines;

  // Header: hint in the high nibble, neighbour count in the low one, capped at eight.
  assign hint  = row_data[0][7:4];
  assign n_raw = row_data[0][3:0];
  assign n_sat = (n_raw > 4'(mcc_pkg::NB_COUNT)) ? 4'(mcc_pkg::NB_COUNT) : n_raw;

  // Count known mines and candidate bits over the active neighbours.
  always_comb begin
    logic [7:0] nb;
    logic [5:0] idx;
    mines = '0;
    for (int j = 1; j <= mcc_pkg::NB_COUNT; j++) begin
      nb  = row_data[j];
      idx = nb[7:2];
      if (4'(j) <= n_sat) begin
        if (nb[1:0] == mcc_pkg::FLAG_MINE) begin
          mines = mines + 4'd1;
        end else if (nb[1:0] != mcc_pkg::FLAG_SAFE &&
                     7'(idx) < 7'(mcc_pkg::MASK_BITS)) begin
          mines = mines + 4'(cand[idx[$clog2(mcc_pkg::MASK_BITS)-1:0]]);
        end
      end
    end
  end

  assign row_ok = (mines == hint);

endmodule

FILE: design/mine_constraint_checker_unit.sv
// Load beat: the byte is written into the table at the accepting edge; the block stays ready.
// Test beat: one table row is read and checked per cycle over N = min(row_count, 64)
// rows (0 allowed); the result is registered after the last row and the next beat
// is taken only after that, so a test ends sooner on an early failing row and later
// while a held result waits for out_ready.
// Synchronous reset (rst_n low) clears config, scan and handshake state, not table or data.
module mine_constraint_checker_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [5:0]                    in_row,
  input  logic [3:0]                    in_slot,
  input  logic [7:0]                    in_table_byte,
  input  logic [31:0]                   in_prediction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_mask_out,
  output logic                          out_constraints_met,
  output logic [5:0]                    out_mine_total,
  output logic                          out_accepted,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [6:0]                    cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0] row_count_r;
  logic [5:0] remaining_mines_r;
  logic       all_in_border_r;

  logic [mcc_pkg::MASK_BITS-1:0] cand_r, cand_nxt;
  logic [mcc_pkg::CNT_W-1:0]     left_r, left_nxt;
  logic [mcc_pkg::ROW_W-1:0]     addr_r, addr_nxt;
  logic                          met_r, met_nxt;

  logic                          out_valid_r;
  logic [31:0]                   mask_r;
  logic                          met_out_r;
  logic [5:0]                    total_r;
  logic                          acc_r;

  logic                          in_fire;
  logic                          out_free;
  logic [mcc_pkg::CNT_W-1:0]     rows_eff;
  mcc_pkg::ram_req_t             req;
  mcc_pkg::row_t                 row_data;
  logic                          row_ok;
  logic [mcc_pkg::TOT_W-1:0]     total;
  logic                          filter_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Row count clamped to the table depth.
  assign rows_eff = (row_count_r > 7'(mcc_pkg::MAX_ROWS)) ?
                    mcc_pkg::CNT_W'(mcc_pkg::MAX_ROWS) : mcc_pkg::CNT_W'(row_count_r);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r       <= '0;
      remaining_mines_r <= '0;
      all_in_border_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mcc_pkg::REG_ROW_COUNT:       row_count_r       <= cfg_wdata;
        mcc_pkg::REG_REMAINING_MINES: remaining_mines_r <= cfg_wdata[5:0];
        mcc_pkg::REG_ALL_IN_BORDER:   all_in_border_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Table access: loads write at the accepting edge, the scan reads one row a cycle.
  always_comb begin
    req       = '0;
    req.we    = in_fire && (in_cmd == mcc_pkg::CMD_LOAD) &&
                (in_slot < 4'(mcc_pkg::ROW_BYTES));
    req.wrow  = in_row;
    req.wslot = in_slot;
    req.wdata = in_table_byte;
    req.raddr = addr_nxt;
    req.re    = 1'b0;
    if (in_fire && in_cmd == mcc_pkg::CMD_TEST && rows_eff != '0) begin
      req.re = 1'b1;
    end else if (state_r == S_RUN && row_ok && left_r != mcc_pkg::CNT_W'(1)) begin
      req.re = 1'b1;
    end
  end

  mcc_table_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (row_data)
  );

  mcc_row_eval u_eval (
    .row_data (row_data),
    .cand     (cand_r),
    .row_ok   (row_ok)
  );

  // Scan sequencer with early exit on the first failing row.
  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    left_nxt  = left_r;
    addr_nxt  = addr_r;
    met_nxt   = met_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_cmd == mcc_pkg::CMD_TEST) begin
          cand_nxt = in_prediction[mcc_pkg::MASK_BITS-1:0];
          met_nxt  = 1'b1;
          left_nxt = rows_eff;
          addr_nxt = '0;
          if (rows_eff == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (!row_ok) begin
          met_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (left_r == mcc_pkg::CNT_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          left_nxt = left_r - mcc_pkg::CNT_W'(1);
          addr_nxt = addr_r + mcc_pkg::ROW_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= '0;
      addr_r  <= '0;
      met_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      addr_r  <= addr_nxt;
      met_r   <= met_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  // Popcount and the remaining-mines filter.
  assign total     = mcc_pkg::popcount(cand_r);
  assign filter_ok = (remaining_mines_r == '0) ||
                     ((6'(total) <= remaining_mines_r) &&
                      (!all_in_border_r || 6'(total) == remaining_mines_r));

  // Output register: holds a finished beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      mask_r    <= 32'(cand_r);
      met_out_r <= met_r;
      total_r   <= 6'(total);
      acc_r     <= met_r && filter_ok;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mask_out        = mask_r;
  assign out_constraints_met = met_out_r;
  assign out_mine_total      = total_r;
  assign out_accepted        = acc_r;

endmodule

FILE: design/mcc_checker.sv
`include "mine_constraint_checker_unit_macros.svh"

module mcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_constraints_met,
  input logic [5:0]  out_mine_total,
  input logic        out_accepted
);

  // A pending result beat is not dropped.
  `MCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Acceptance never overrides failed constraints.
  `MCC_ASSERT_NOW(a_acc_met, out_valid && out_accepted, out_constraints_met)

  // The popcount of a 32-bit mask cannot exceed 32.
  `MCC_ASSERT_NOW(a_total_range, out_valid, out_mine_total <= 6'd32)

  // A test beat occupies the block, so the next input beat waits.
  `MCC_ASSERT_NEXT(a_test_busy, in_valid && in_ready && in_cmd == mcc_pkg::CMD_TEST, !in_ready)

endmodule

bind mine_constraint_checker_unit mcc_checker u_mcc_checker (.*);

FILE: test/tb_mine_constraint_checker_unit.sv
module tb_mine_constraint_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index with no register behind it, and the two flag codes that
  // leave the count to the candidate mask.
  localparam logic [1:0] REG_SPARE     = 2'd3;
  localparam logic [1:0] FLAG_OPEN     = 2'd0;
  localparam logic [1:0] FLAG_OPEN_ALT = 2'd3;

  // Settling wait sized from the full table depth, so that a full-table test can finish.
  localparam int SETTLE_CYCLES = mcc_pkg::MAX_ROWS + 8;
  localparam int PHASE_ITEMS   = 90;
  localparam int PHASES        = 8;

  // Idling modes: none, sender only, receiver only, both.
  localparam int SENDER_IDLE_PCT [4] = '{0, 80, 0, 36};
  localparam int RECEIVER_STALL_PCT [4] = '{0, 0, 80, 36};

  typedef struct packed {
    logic        cmd;
    logic [5:0]  row;
    logic [3:0]  slot;
    logic [7:0]  tbyte;
    logic [31:0] pred;
  } beat_t;

  typedef struct packed {
    logic [31:0] mask;
    logic        met;
    logic [5:0]  total;
    logic        acc;
  } verdict_t;

  typedef enum {
    SEND_LOAD, SEND_TEST, SEND_TEST_KNOWN,
    SET_ROW_COUNT, SET_REMAINING, SET_BORDER, SET_SPARE
  } step_kind_t;

  // One row of the directed table: kind, row, slot, data, candidate, and the
  // verdict fields that are only used by SEND_TEST_KNOWN rows.
  typedef struct {
    step_kind_t  kind;
    int          row;
    int          slot;
    int          data;
    logic [31:0] pred;
    int          met;
    int          total;
    int          acc;
  } dir_step_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [5:0]  in_row;
  logic [3:0]  in_slot;
  logic [7:0]  in_table_byte;
  logic [31:0] in_prediction;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_mask_out;
  logic        out_constraints_met;
  logic [5:0]  out_mine_total;
  logic        out_accepted;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_wdata;

  // Shadow copy of the table and registers, and the verdicts still to come.
  mcc_pkg::row_t table_model [mcc_pkg::MAX_ROWS];
  logic [6:0]    rows_setting;
  logic [5:0]    mines_setting;
  logic          border_setting;
  verdict_t      verdicts_due [$];
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  // Hidden mine layout that well-formed rows agree with, and the cells that
  // open neighbours may refer to; cells outside it are free.
  logic [31:0] solution;
  logic [31:0] border_bits;
  int          noisy_row;

  // Row 0 holds hint 5 with a neighbour count of 15, which saturates to 8.
  // Its neighbours cover every flag, an index of exactly 32 and one of 63.
  dir_step_t directed_steps [25] = '{
    '{SEND_TEST_KNOWN, 0, 0, 0, 32'h0000_0000, 1, 0, 1},
    '{SEND_TEST_KNOWN, 0, 0, 0, 32'hFFFF_FFFF, 1, 32, 1},
    '{SEND_LOAD, 0, 0, 8'h5F, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 0, 1, 8'h01, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 0, 2, 8'h16, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 0, 3, 8'h00, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 0, 4, 8'h7F, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 0, 5, 8'h80, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 0, 6, 8'hFF, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 0, 7, 8'h04, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 0, 8, 8'hFD, 32'h0000_0000, 0, 0, 0},
    // Slots past the end of a row are dropped.
    '{SEND_LOAD, 0, 9, 8'hAA, 32'h0000_0000, 0, 0, 0},
    '{SEND_LOAD, 63, 15, 8'hFF, 32'h0000_0000, 0, 0, 0},
    '{SET_ROW_COUNT, 0, 0, 1, 32'h0000_0000, 0, 0, 0},
    '{SEND_TEST, 0, 0, 0, 32'h8000_0003, 0, 0, 0},
    '{SEND_TEST, 0, 0, 0, 32'h0000_0003, 0, 0, 0},
    '{SEND_TEST, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0},
    '{SET_REMAINING, 0, 0, 3, 32'h0000_0000, 0, 0, 0},
    '{SEND_TEST, 0, 0, 0, 32'h8000_0003, 0, 0, 0},
    '{SEND_TEST, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0},
    '{SET_BORDER, 0, 0, 1, 32'h0000_0000, 0, 0, 0},
    '{SEND_TEST, 0, 0, 0, 32'h8000_0023, 0, 0, 0},
    '{SEND_TEST, 0, 0, 0, 32'h0000_0003, 0, 0, 0},
    '{SET_SPARE, 0, 0, 127, 32'h0000_0000, 0, 0, 0},
    '{SEND_TEST, 0, 0, 0, 32'h8000_0003, 0, 0, 0}
  };

  mine_constraint_checker_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_row              (in_row),
    .in_slot             (in_slot),
    .in_table_byte       (in_table_byte),
    .in_prediction       (in_prediction),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mask_out        (out_mask_out),
    .out_constraints_met (out_constraints_met),
    .out_mine_total      (out_mine_total),
    .out_accepted        (out_accepted),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mines counted in one row for a candidate: known mines always, known safe
  // cells never, open cells by the candidate bit, which is zero past bit 31.
  function automatic int unsigned row_mines(mcc_pkg::row_t r, logic [31:0] cand);
    int unsigned n;
    int unsigned cnt;
    logic [7:0]  nb;
    n = r[0][3:0];
    if (n > mcc_pkg::NB_COUNT) n = mcc_pkg::NB_COUNT;
    cnt = 0;
    for (int j = 1; j <= mcc_pkg::NB_COUNT; j++) begin
      nb = r[j];
      if (j <= n) begin
        if (nb[1:0] == mcc_pkg::FLAG_MINE) cnt++;
        else if (nb[1:0] != mcc_pkg::FLAG_SAFE && nb[7:2] < mcc_pkg::MASK_BITS)
          cnt += cand[nb[7:2]];
      end
    end
    return cnt;
  endfunction

  // Verdict for one test beat under the current table and registers.
  function automatic verdict_t predict_verdict(logic [31:0] cand);
    verdict_t v;
    int       lim;
    bit       met;
    lim = (rows_setting > mcc_pkg::MAX_ROWS) ? mcc_pkg::MAX_ROWS : int'(rows_setting);
    met = 1'b1;
    for (int r = 0; r < lim && met; r++) begin
      met = (row_mines(table_model[r], cand) == table_model[r][0][7:4]);
    end
    v.mask  = cand;
    v.met   = met;
    v.total = 6'($countones(cand));
    v.acc   = met;
    if (mines_setting != 0) begin
      if (v.total > mines_setting) v.acc = 1'b0;
      if (border_setting && v.total != mines_setting) v.acc = 1'b0;
    end
    return v;
  endfunction

  // A row that agrees with the hidden layout, or pure noise.
  function automatic mcc_pkg::row_t make_row(bit noisy);
    mcc_pkg::row_t r;
    logic [1:0]    flag;
    logic [5:0]    idx;
    logic [3:0]    n;
    for (int j = 1; j < mcc_pkg::ROW_BYTES; j++) begin
      case ($urandom_range(9))
        0, 1: flag = mcc_pkg::FLAG_MINE;
        2: flag = mcc_pkg::FLAG_SAFE;
        default: flag = $urandom_range(1) ? FLAG_OPEN : FLAG_OPEN_ALT;
      endcase
      if (flag == mcc_pkg::FLAG_MINE || flag == mcc_pkg::FLAG_SAFE) begin
        idx = 6'($urandom_range(63));
      end else if ($urandom_range(9) == 0) begin
        idx = 6'($urandom_range(mcc_pkg::MASK_BITS, 63));
      end else begin
        do idx = 6'($urandom_range(mcc_pkg::MASK_BITS - 1)); while (!border_bits[idx]);
      end
      r[j] = {idx, flag};
    end
    n = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) :
                                   4'($urandom_range(1, mcc_pkg::NB_COUNT));
    r[0] = {4'd0, n};
    r[0] = {4'(row_mines(r, solution)), n};
    if (noisy) begin
      for (int j = 0; j < mcc_pkg::ROW_BYTES; j++) r[j] = 8'($urandom);
    end
    return r;
  endfunction

  // Candidates mostly near the hidden layout, so that tests get deep rows.
  function automatic logic [31:0] pick_candidate();
    case ($urandom_range(4))
      0: return solution;
      1, 2: return solution ^ ($urandom & ~border_bits);
      3: return solution ^ (32'd1 << $urandom_range(mcc_pkg::MASK_BITS - 1));
      default: return $urandom;
    endcase
  endfunction

  // Rows inside the checked range are favoured.
  function automatic int pick_row();
    int lim;
    lim = (rows_setting > mcc_pkg::MAX_ROWS) ? mcc_pkg::MAX_ROWS : int'(rows_setting);
    if (lim > 0 && $urandom_range(1)) return $urandom_range(lim - 1);
    return $urandom_range(mcc_pkg::MAX_ROWS - 1);
  endfunction

  // Offers one beat after a random gap and holds it until it is taken. The
  // shadow state is updated at the accepting edge.
  task automatic send_beat(beat_t b, bit known, verdict_t want);
    verdict_t due;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= b.cmd;
    in_row        <= b.row;
    in_slot       <= b.slot;
    in_table_byte <= b.tbyte;
    in_prediction <= b.pred;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (b.cmd == mcc_pkg::CMD_LOAD) begin
      if (b.slot < mcc_pkg::ROW_BYTES) table_model[b.row][b.slot] = b.tbyte;
    end else begin
      due = known ? want : predict_verdict(b.pred);
      verdicts_due = {verdicts_due, due};
    end
  endtask

  task automatic send_load(int row, int slot, logic [7:0] data);
    beat_t    b;
    verdict_t none;
    none    = '0;
    b.cmd   = mcc_pkg::CMD_LOAD;
    b.row   = 6'(row);
    b.slot  = 4'(slot);
    b.tbyte = data;
    b.pred  = $urandom;
    send_beat(b, 1'b0, none);
  endtask

  task automatic send_test(logic [31:0] cand, bit known, verdict_t want);
    beat_t b;
    b.cmd   = mcc_pkg::CMD_TEST;
    b.row   = 6'($urandom);
    b.slot  = 4'($urandom);
    b.tbyte = 8'($urandom);
    b.pred  = cand;
    send_beat(b, known, want);
  endtask

  task automatic send_row(int r, mcc_pkg::row_t data);
    for (int j = 0; j < mcc_pkg::ROW_BYTES; j++) send_load(r, j, data[j]);
  endtask

  // Registers change only once the block has drained and settled.
  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      mcc_pkg::REG_ROW_COUNT:       rows_setting = val;
      mcc_pkg::REG_REMAINING_MINES: mines_setting = val[5:0];
      mcc_pkg::REG_ALL_IN_BORDER:   border_setting = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int rc, int rm, int aib);
    write_reg(mcc_pkg::REG_ROW_COUNT, 7'(rc));
    write_reg(mcc_pkg::REG_REMAINING_MINES, 7'(rm));
    write_reg(mcc_pkg::REG_ALL_IN_BORDER, 7'(aib));
  endtask

  // Result side: checks each beat against the oldest verdict, then decides
  // whether to stall for the next cycle.
  initial begin
    verdict_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result beat with nothing expected, mask_out %h", out_mask_out);
          mismatch_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_mask_out !== want.mask) begin
            $error("mask_out: expected %h, got %h", want.mask, out_mask_out);
            mismatch_count++;
          end
          if (out_constraints_met !== want.met) begin
            $error("constraints_met: expected %0d, got %0d", want.met, out_constraints_met);
            mismatch_count++;
          end
          if (out_mine_total !== want.total) begin
            $error("mine_total: expected %0d, got %0d", want.total, out_mine_total);
            mismatch_count++;
          end
          if (out_accepted !== want.acc) begin
            $error("accepted: expected %0d, got %0d", want.acc, out_accepted);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus: directed table, full table load, then random phases.
  initial begin
    verdict_t   want;
    dir_step_t  st;
    int         items;
    logic [5:0] base;

    want           = '0;
    rows_setting   = '0;
    mines_setting  = '0;
    border_setting = 1'b0;
    noisy_row      = -1;
    for (int r = 0; r < mcc_pkg::MAX_ROWS; r++) table_model[r] = '0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= mcc_pkg::CMD_LOAD;
    in_row        <= '0;
    in_slot       <= '0;
    in_table_byte <= '0;
    in_prediction <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= mcc_pkg::REG_ROW_COUNT;
    cfg_wdata     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      case (st.kind)
        SEND_LOAD: send_load(st.row, st.slot, 8'(st.data));
        SEND_TEST: send_test(st.pred, 1'b0, want);
        SEND_TEST_KNOWN: begin
          want.mask  = st.pred;
          want.met   = 1'(st.met);
          want.total = 6'(st.total);
          want.acc   = 1'(st.acc);
          send_test(st.pred, 1'b1, want);
        end
        SET_ROW_COUNT: write_reg(mcc_pkg::REG_ROW_COUNT, 7'(st.data));
        SET_REMAINING: write_reg(mcc_pkg::REG_REMAINING_MINES, 7'(st.data));
        SET_BORDER:    write_reg(mcc_pkg::REG_ALL_IN_BORDER, 7'(st.data));
        default:       write_reg(REG_SPARE, 7'(st.data));
      endcase
    end

    // Every row is written in full before any test may reach past row 0.
    solution    = $urandom;
    border_bits = ($urandom & $urandom) | (32'd1 << $urandom_range(mcc_pkg::MASK_BITS - 1));
    for (int r = 0; r < mcc_pkg::MAX_ROWS; r++) send_row(r, make_row(1'b0));

    for (int phase = 0; phase < PHASES; phase++) begin
      base = 6'($countones(solution));
      case (phase)
        0: apply_settings(1, 0, 0);
        1: apply_settings(mcc_pkg::MAX_ROWS, 32, 0);
        2: apply_settings(127, base, 1);
        3: apply_settings(3, 63, 1);
        4: apply_settings(8, (base > 61) ? 63 : base + 2, 0);
        5: apply_settings(0, 5, 1);
        6: apply_settings(16, base, 0);
        default: apply_settings(mcc_pkg::MAX_ROWS, 0, 1);
      endcase
      send_idle_pct  = SENDER_IDLE_PCT[phase % 4];
      recv_stall_pct = RECEIVER_STALL_PCT[phase % 4];

      items = 0;
      while (items < PHASE_ITEMS) begin
        case ($urandom_range(19))
          0, 1: begin
            // A noise row is repaired by the next rewrite so that valid
            // candidates stay reachable for most of the phase.
            if (noisy_row >= 0) begin
              send_row(noisy_row, make_row(1'b0));
              noisy_row = -1;
            end else if ($urandom_range(4) == 0) begin
              noisy_row = pick_row();
              send_row(noisy_row, make_row(1'b1));
            end else begin
              send_row(pick_row(), make_row(1'b0));
            end
            items += mcc_pkg::ROW_BYTES;
          end
          2: send_load($urandom_range(mcc_pkg::MAX_ROWS - 1),
                       $urandom_range(mcc_pkg::ROW_BYTES, 15), 8'($urandom));
          default: begin
            send_test(pick_candidate(), 1'b0, want);
            items++;
          end
        endcase
      end
    end

    // Drain, then give the block time to show any stray result beat.
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && verdicts_due.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $error("%0d result beats never arrived", verdicts_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/mcc_pkg.sv
design/mcc_table_ram.sv
design/mcc_row_eval.sv
design/mine_constraint_checker_unit.sv
design/mcc_checker.sv
test/tb_mine_constraint_checker_unit.sv
